// File: rtl/core/prq_pkg.sv
package prq_pkg;

    localparam int PRQ_DEPTH = 64;
    localparam int PID_W     = 16;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE  = 3'd0,
        OP_DEQUEUE  = 3'd1,
        OP_PEEK     = 3'd2,
        OP_REMOVE   = 3'd3,
        OP_CONTAINS = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

endpackage

// File: rtl/core/pid_req_if.sv
interface pid_req_if;
    import prq_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [PID_W-1:0]  pid_value;

    modport source (output valid, output opcode, output pid_value, input ready);
    modport sink   (input valid, input opcode, input pid_value, output ready);
endinterface

// File: rtl/core/pid_rsp_if.sv
interface pid_rsp_if #(
    parameter int CNT_W = 7
);
    import prq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PID_W-1:0]     read_value;
    logic [STATUS_W-1:0]  status;
    logic                 found;
    logic [CNT_W-1:0]     occupancy;

    modport source (output valid, output read_value, output status, output found,
                    output occupancy, input ready);
    modport sink   (input valid, input read_value, input status, input found,
                    input occupancy, output ready);
endinterface

// File: rtl/core/prq_mem.sv
module prq_mem #(
    parameter int DEPTH  = prq_pkg::PRQ_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = prq_pkg::PID_W
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/pid_ring_queue_with_removal.sv
// enqueue, dequeue, peek: the exec state registers the result once the output register is free
// remove, contains: the scan state reads every held entry (none on an empty queue), then registers the result
// one memory read per held entry; remove repacks in place behind the read pointer
// the input is taken again on the cycle after the result is loaded into the output register
// reset (rst_n low, asynchronous) empties the queue; entry memory keeps old contents
module pid_ring_queue_with_removal #(
    parameter int QUEUE_DEPTH = prq_pkg::PRQ_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    pid_req_if.sink    cmd,
    pid_rsp_if.source  res
);
    import prq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

    function automatic logic [IDX_W-1:0] ring_add(
        input logic [IDX_W-1:0] base,
        input logic [CNT_W-1:0] off
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= DEPTH_SUM)
        begin
            s = s - DEPTH_SUM;
        end
        return s[IDX_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    op_t                op_reg, op_next;
    logic [PID_W-1:0]   pid_reg, pid_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]   kept_reg, kept_next;
    logic               pend_reg, pend_next;
    logic               hit_reg, hit_next;

    logic               out_valid_reg, out_valid_next;
    logic [PID_W-1:0]   out_value_reg, out_value_next;
    status_t            out_status_reg, out_status_next;
    logic               out_found_reg, out_found_next;
    logic [CNT_W-1:0]   out_occ_reg, out_occ_next;

    logic               out_free;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [PID_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [PID_W-1:0]   mem_rdata;

    prq_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (PID_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cmd.ready      = (state_reg == S_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.read_value = out_value_reg;
    assign res.status     = out_status_reg;
    assign res.found      = out_found_reg;
    assign res.occupancy  = out_occ_reg;
    assign out_free       = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            kept_reg      <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            kept_reg      <= kept_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pid_reg        <= pid_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_occ_reg    <= out_occ_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        pid_next        = pid_reg;
        scan_idx_next   = scan_idx_reg;
        kept_next       = kept_reg;
        pend_next       = pend_reg;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_occ_next    = out_occ_reg;
        mem_we          = 1'b0;
        mem_waddr       = tail_reg;
        mem_wdata       = pid_reg;
        mem_re          = 1'b0;
        mem_raddr       = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // prefetch the oldest entry for dequeue and peek
                mem_re = 1'b1;
                if (cmd.valid)
                begin
                    op_next       = op_t'(cmd.opcode);
                    pid_next      = cmd.pid_value;
                    scan_idx_next = '0;
                    kept_next     = '0;
                    pend_next     = 1'b0;
                    hit_next      = 1'b0;
                    if (op_t'(cmd.opcode) == OP_REMOVE || op_t'(cmd.opcode) == OP_CONTAINS)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = ST_OK;
                    out_found_next  = 1'b0;
                    out_occ_next    = count_reg;
                    unique case (op_reg)
                        OP_ENQUEUE:
                        begin
                            if (count_reg == DEPTH_CNT)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                tail_next    = ring_add(tail_reg, CNT_W'(1));
                                count_next   = count_reg + CNT_W'(1);
                                out_occ_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEQUEUE, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                out_value_next = mem_rdata;
                                if (op_reg == OP_DEQUEUE)
                                begin
                                    head_next    = ring_add(head_reg, CNT_W'(1));
                                    count_next   = count_reg - CNT_W'(1);
                                    out_occ_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg != count_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = ring_add(head_reg, scan_idx_reg);
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // compact survivors toward the head, never past the read pointer
                if (pend_reg)
                begin
                    if (mem_rdata == pid_reg)
                    begin
                        hit_next = 1'b1;
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = ring_add(head_reg, kept_reg);
                        mem_wdata = mem_rdata;
                        kept_next = kept_reg + CNT_W'(1);
                    end
                end

                if (scan_idx_reg == count_reg && !pend_reg && out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = ST_OK;
                    if (op_reg == OP_REMOVE)
                    begin
                        count_next     = kept_reg;
                        tail_next      = ring_add(head_reg, kept_reg);
                        out_found_next = 1'b0;
                        out_occ_next   = kept_reg;
                    end
                    else
                    begin
                        out_found_next = hit_reg;
                        out_occ_next   = count_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/prq_checker.sv
module prq_checker #(
    parameter int QUEUE_DEPTH = prq_pkg::PRQ_DEPTH,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [prq_pkg::PID_W-1:0]     res_read_value,
    input logic [prq_pkg::STATUS_W-1:0]  res_status,
    input logic                          res_found,
    input logic [CNT_W-1:0]              res_occupancy
);
    import prq_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_occupancy <= DEPTH_CNT)
        else $error("occupancy above queue depth");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_status == ST_FULL) |-> res_occupancy == DEPTH_CNT)
        else $error("full reported with free space");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_status == ST_EMPTY) |-> (res_occupancy == '0 && res_read_value == '0))
        else $error("empty reported with entries or data");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("second beat taken while busy");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_read_value)
            && $stable(res_status) && $stable(res_found) && $stable(res_occupancy)))
        else $error("result changed while stalled");

endmodule

bind pid_ring_queue_with_removal prq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_prq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_read_value (res.read_value),
    .res_status     (res.status),
    .res_found      (res.found),
    .res_occupancy  (res.occupancy)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import prq_pkg::*;

    localparam int OCC_W          = $clog2(PRQ_DEPTH + 1);
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = PRQ_DEPTH + 8;
    localparam int POOL_SIZE      = 6;

    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    typedef struct {
        logic [PID_W-1:0]    read_value;
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [OCC_W-1:0]    occupancy;
    } pid_result_t;

    logic clk;
    logic rst_n;

    pid_req_if                   cmd_if ();
    pid_rsp_if #(.CNT_W(OCC_W))  rsp_if ();

    pid_ring_queue_with_removal u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .res   (rsp_if.source)
    );

    logic [PID_W-1:0] held_pids[$];
    pid_result_t      pending_results[$];
    logic [PID_W-1:0] pid_pool[POOL_SIZE];
    int unsigned      error_count;
    int unsigned      quiet_cycles;
    bit               source_gaps;
    bit               sink_gaps;
    bit               hold_request;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic bit is_held(logic [PID_W-1:0] pid);
        foreach (held_pids[i])
        begin
            if (held_pids[i] == pid)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic pid_result_t predict_queue_op(logic [OP_W-1:0] op, logic [PID_W-1:0] pid);
        pid_result_t      r;
        logic [PID_W-1:0] kept[$];
        r = '{default: '0};
        case (op)
            OP_ENQUEUE:
            begin
                if (held_pids.size() >= PRQ_DEPTH)
                    r.status = ST_FULL;
                else
                    held_pids.push_back(pid);
            end
            OP_DEQUEUE, OP_PEEK:
            begin
                if (held_pids.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.read_value = held_pids[0];
                    if (op == OP_DEQUEUE)
                        void'(held_pids.pop_front());
                end
            end
            OP_REMOVE:
            begin
                foreach (held_pids[i])
                begin
                    if (held_pids[i] != pid)
                        kept.push_back(held_pids[i]);
                end
                held_pids = kept;
            end
            OP_CONTAINS:
                r.found = is_held(pid);
            default:
            begin
            end
        endcase
        r.occupancy = OCC_W'(held_pids.size());
        return r;
    endfunction

    function automatic logic [PID_W-1:0] random_pid();
        if ($urandom_range(0, 99) < 75)
            return pid_pool[$urandom_range(0, POOL_SIZE - 1)];
        return PID_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid);
        while (source_gaps && $urandom_range(0, 99) < 7)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.opcode    <= op;
        cmd_if.pid_value <= pid;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        pending_results.push_back(predict_queue_op(op, pid));
    endtask

    // result sink with random stalls and a long hold-off on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (!rst_n || hold_left != 0)
            begin
                rsp_if.ready <= 1'b0;
                if (hold_left != 0)
                    hold_left--;
            end
            else
                rsp_if.ready <= !(sink_gaps && $urandom_range(0, 99) < 7);
        end
    end

    function automatic void check_field(string field_name, int unsigned exp_v,
                                        int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field_name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        pid_result_t oldest;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual value 0x%0h "
                         , $time, rsp_if.read_value);
                error_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("read_value", 32'(oldest.read_value), 32'(rsp_if.read_value));
                check_field("status", 32'(oldest.status), 32'(rsp_if.status));
                check_field("found", 32'(oldest.found), 32'(rsp_if.found));
                check_field("occupancy", 32'(oldest.occupancy), 32'(rsp_if.occupancy));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[pid_ring_queue_with_removal] ERROR");
            $finish;
        end
    end

    task automatic test_empty_queue();
        send_cmd(OP_DEQUEUE, 16'h0000);
        send_cmd(OP_PEEK, 16'hFFFF);
        send_cmd(OP_CONTAINS, 16'h0000);
        send_cmd(OP_REMOVE, 16'h0000);
        send_cmd(OP_RSVD_5, 16'hFFFF);
        send_cmd(OP_RSVD_6, 16'h0000);
        send_cmd(OP_RSVD_7, 16'hFFFF);
    endtask

    task automatic test_basic_ops();
        send_cmd(OP_ENQUEUE, 16'h0000);
        send_cmd(OP_ENQUEUE, 16'hFFFF);
        send_cmd(OP_ENQUEUE, 16'h1234);
        send_cmd(OP_ENQUEUE, 16'hFFFF);
        send_cmd(OP_ENQUEUE, 16'h0000);
        send_cmd(OP_PEEK, 16'hFFFF);
        send_cmd(OP_CONTAINS, 16'hFFFF);
        send_cmd(OP_CONTAINS, 16'h5555);
        send_cmd(OP_REMOVE, 16'hFFFF);
        send_cmd(OP_CONTAINS, 16'hFFFF);
        send_cmd(OP_REMOVE, 16'h7777);
        send_cmd(OP_DEQUEUE, 16'hAAAA);
        send_cmd(OP_DEQUEUE, 16'h0000);
        send_cmd(OP_DEQUEUE, 16'hFFFF);
        send_cmd(OP_DEQUEUE, 16'h0000);
        send_cmd(OP_ENQUEUE, 16'hAAAA);
        send_cmd(OP_RSVD_7, 16'h0000);
        send_cmd(OP_PEEK, 16'h0000);
    endtask

    task automatic test_fill_to_full();
        logic [PID_W-1:0] absent_pid;
        while (held_pids.size() < PRQ_DEPTH)
            send_cmd(OP_ENQUEUE, random_pid());
        repeat (3)
            send_cmd(OP_ENQUEUE, random_pid());
        send_cmd(OP_CONTAINS, pid_pool[0]);
        send_cmd(OP_CONTAINS, random_pid());
        send_cmd(OP_PEEK, random_pid());
        absent_pid = random_pid();
        while (is_held(absent_pid))
            absent_pid = PID_W'($urandom_range(0, 65535));
        // full queue with no match wraps the write slot back to the head slot
        send_cmd(OP_REMOVE, absent_pid);
        send_cmd(OP_ENQUEUE, random_pid());
        repeat (10)
            send_cmd(OP_DEQUEUE, random_pid());
        repeat (12)
            send_cmd(OP_ENQUEUE, random_pid());
        send_cmd(OP_CONTAINS, random_pid());
        send_cmd(OP_REMOVE, pid_pool[$urandom_range(0, POOL_SIZE - 1)]);
        while (held_pids.size() != 0)
            send_cmd(OP_DEQUEUE, random_pid());
        send_cmd(OP_DEQUEUE, random_pid());
        send_cmd(OP_PEEK, random_pid());
    endtask

    task automatic test_input_stall();
        hold_request = 1'b1;
        repeat (30)
        begin
            if ($urandom_range(0, 3) == 0)
                send_cmd(OP_CONTAINS, random_pid());
            else
                send_cmd(OP_ENQUEUE, random_pid());
        end
    endtask

    task automatic test_random_mix(input int unsigned n_items);
        int unsigned      pick;
        bit               grow;
        logic [OP_W-1:0]  op;
        for (int unsigned k = 0; k < n_items; k++)
        begin
            grow = ((k / 100) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < (grow ? 55 : 20))
                op = OP_ENQUEUE;
            else if (pick < 70)
                op = OP_DEQUEUE;
            else if (pick < 78)
                op = OP_PEEK;
            else if (pick < 86)
                op = OP_REMOVE;
            else if (pick < 98)
                op = OP_CONTAINS;
            else
                op = OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
            send_cmd(op, random_pid());
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.opcode    = OP_ENQUEUE;
        cmd_if.pid_value = '0;
        error_count      = 0;
        quiet_cycles     = 0;
        source_gaps      = 1'b1;
        sink_gaps        = 1'b1;
        hold_request     = 1'b0;
        pid_pool[0] = 16'h0000;
        pid_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            pid_pool[i] = PID_W'($urandom_range(0, 65535));
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_basic_ops();
        test_fill_to_full();
        test_input_stall();
        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
        test_random_mix(150);
        source_gaps = 1'b1;
        sink_gaps   = 1'b1;
        test_random_mix(400);

        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("[pid_ring_queue_with_removal] OK");
        else
            $display("[pid_ring_queue_with_removal] ERROR");
        $finish;
    end

endmodule
